### hw/rtl/pcdin_pkg.sv
// pcdin_pkg: shared types, character constants and sequence positions for the
// $PCDIN sentence encoder. No dependencies.

package pcdin_pkg;

   // fields of one input word
   typedef struct packed {
      logic        first_item;
      logic        last_item;
      logic        has_byte;
      logic [7:0]  data_byte;
      logic [23:0] pgn_value;
      logic [31:0] time_stamp;
      logic [7:0]  source_addr;
   } req_type;

   // fields of one result word
   typedef struct packed {
      logic [7:0] out_char;
      logic       run_end;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   localparam int POS_W = 6;
   typedef logic [POS_W-1:0] pos_type;

   // positions of the full character sequence of one word
   localparam pos_type POS_DOLLAR    = 6'd0;
   localparam pos_type POS_TAG_FIRST = 6'd1;
   localparam pos_type POS_TAG_LAST  = 6'd6;
   localparam pos_type POS_PGN_FIRST = 6'd7;
   localparam pos_type POS_PGN_LAST  = 6'd12;
   localparam pos_type POS_PGN_COMMA = 6'd13;
   localparam pos_type POS_TS_FIRST  = 6'd14;
   localparam pos_type POS_TS_LAST   = 6'd21;
   localparam pos_type POS_TS_COMMA  = 6'd22;
   localparam pos_type POS_SRC_FIRST = 6'd23;
   localparam pos_type POS_SRC_LAST  = 6'd24;
   localparam pos_type POS_HDR_LAST  = 6'd25;
   localparam pos_type POS_BYTE_FIRST = 6'd26;
   localparam pos_type POS_BYTE_LAST = 6'd27;
   localparam pos_type POS_TRL_FIRST = 6'd28;
   localparam pos_type POS_SUM_FIRST = 6'd29;
   localparam pos_type POS_SUM_LAST  = 6'd30;
   localparam pos_type POS_CR        = 6'd31;
   localparam pos_type POS_TRL_LAST  = 6'd32;

   localparam logic [7:0]  CH_DOLLAR = 8'h24;
   localparam logic [7:0]  CH_COMMA  = 8'h2C;
   localparam logic [7:0]  CH_STAR   = 8'h2A;
   localparam logic [7:0]  CH_CR     = 8'h0D;
   localparam logic [7:0]  CH_LF     = 8'h0A;
   localparam logic [7:0]  CH_ZERO   = 8'h30;
   localparam logic [7:0]  CH_A      = 8'h41;
   // "PCDIN," with the first letter in the top byte
   localparam logic [47:0] PCDIN_TAG = 48'h5043_4449_4E2C;

   // uppercase hex digit of one nibble
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = CH_ZERO + {4'd0, nib};
      end else begin
         ch = CH_A + {4'd0, nib} - 8'd10;
      end
      return ch;
   endfunction

endpackage

### hw/rtl/pcdin_chargen.sv
// pcdin_chargen: character for one position of the sentence sequence, with
// the shared hex digit unit. Depends on pcdin_pkg.

module pcdin_chargen import pcdin_pkg::*; (
   input  pos_type    pos,
   input  req_type    item,
   input  logic [7:0] sum,
   output logic [7:0] char_out,
   output logic       add_sum
);

   logic [3:0] nib;
   logic       use_hex;
   logic [7:0] lit;
   logic [2:0] tag_idx;
   logic [2:0] pgn_idx;
   logic [2:0] ts_idx;

   // digit index counted from the least significant end
   assign tag_idx = 3'(POS_TAG_LAST - pos);
   assign pgn_idx = 3'(POS_PGN_LAST - pos);
   assign ts_idx  = 3'(POS_TS_LAST - pos);

   always_comb begin
      nib     = 4'd0;
      use_hex = 1'b0;
      lit     = 8'd0;
      unique case (pos) inside
         POS_DOLLAR: begin
            lit = CH_DOLLAR;
         end
         [POS_TAG_FIRST:POS_TAG_LAST]: begin
            lit = PCDIN_TAG[{tag_idx, 3'b000} +: 8];
         end
         [POS_PGN_FIRST:POS_PGN_LAST]: begin
            use_hex = 1'b1;
            nib     = item.pgn_value[{pgn_idx, 2'b00} +: 4];
         end
         POS_PGN_COMMA, POS_TS_COMMA, POS_HDR_LAST: begin
            lit = CH_COMMA;
         end
         [POS_TS_FIRST:POS_TS_LAST]: begin
            use_hex = 1'b1;
            nib     = item.time_stamp[{ts_idx, 2'b00} +: 4];
         end
         POS_SRC_FIRST: begin
            use_hex = 1'b1;
            nib     = item.source_addr[7:4];
         end
         POS_SRC_LAST: begin
            use_hex = 1'b1;
            nib     = item.source_addr[3:0];
         end
         POS_BYTE_FIRST: begin
            use_hex = 1'b1;
            nib     = item.data_byte[7:4];
         end
         POS_BYTE_LAST: begin
            use_hex = 1'b1;
            nib     = item.data_byte[3:0];
         end
         POS_TRL_FIRST: begin
            lit = CH_STAR;
         end
         POS_SUM_FIRST: begin
            use_hex = 1'b1;
            nib     = sum[7:4];
         end
         POS_SUM_LAST: begin
            use_hex = 1'b1;
            nib     = sum[3:0];
         end
         POS_CR: begin
            lit = CH_CR;
         end
         POS_TRL_LAST: begin
            lit = CH_LF;
         end
         default: begin
            lit = 8'd0;
         end
      endcase
   end

   assign char_out = use_hex ? hex_char(nib) : lit;
   // checksum covers everything after the dollar up to and including the payload
   assign add_sum  = (pos >= POS_TAG_FIRST) && (pos <= POS_BYTE_LAST);

endmodule

### hw/rtl/pcdin_sentence_encoder_core.sv
// pcdin_sentence_encoder_core: top level of the $PCDIN sentence encoder.
// Depends on pcdin_pkg and pcdin_chargen.
//
// Each accepted word emits its characters on rsp one per clock while the
// output is not stalled: 26 header characters when first_item is set, two hex
// characters when has_byte is set and the 5-character trailer (star, two
// checksum digits, CR, LF) when last_item is set, at most 33 in all; run_end
// marks the last character of the word. req_stall stays high from the accept
// until the last character of the word has been registered on rsp; a single
// position counter steps through the sequence and one hex digit unit and one
// checksum register are shared by all of it. A word with no flag set emits
// nothing and the block stays ready.

module pcdin_sentence_encoder_core import pcdin_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   state_type  state_ff, state_in;
   pos_type    pos_ff, pos_in;
   req_type    item_ff, item_in;
   logic [7:0] xor_ff, xor_in;
   rsp_type    rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic       accept;
   logic       any_flag;
   logic       advance;
   pos_type    start_pos;
   pos_type    nxt_pos;
   logic       nxt_ok;
   logic [7:0] gen_char;
   logic       gen_add;

   pcdin_chargen u_chargen (
      .pos      (pos_ff),
      .item     (item_ff),
      .sum      (xor_ff),
      .char_out (gen_char),
      .add_sum  (gen_add)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign any_flag  = req.first_item || req.last_item || req.has_byte;
   assign advance   = (state_ff == ST_RUN) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      if (req.first_item) begin
         start_pos = POS_DOLLAR;
      end else if (req.has_byte) begin
         start_pos = POS_BYTE_FIRST;
      end else begin
         start_pos = POS_TRL_FIRST;
      end
   end

   // skip the segments this word does not ask for
   always_comb begin
      nxt_pos = pos_ff + 6'd1;
      nxt_ok  = 1'b1;
      if (pos_ff == POS_HDR_LAST) begin
         nxt_pos = item_ff.has_byte ? POS_BYTE_FIRST : POS_TRL_FIRST;
         nxt_ok  = item_ff.has_byte || item_ff.last_item;
      end else if (pos_ff == POS_BYTE_LAST) begin
         nxt_pos = POS_TRL_FIRST;
         nxt_ok  = item_ff.last_item;
      end else if (pos_ff == POS_TRL_LAST) begin
         nxt_ok  = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && any_flag) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (advance && !nxt_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pos_in       = pos_ff;
      item_in      = item_ff;
      xor_in       = xor_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         pos_in  = start_pos;
         item_in = req;
         if (req.first_item) begin
            xor_in = 8'd0;
         end
      end else if (advance) begin
         pos_in          = nxt_pos;
         rsp_in.out_char = gen_char;
         rsp_in.run_end  = !nxt_ok;
         rsp_valid_in    = 1'b1;
         if (pos_ff == POS_TRL_LAST) begin
            xor_in = 8'd0;
         end else if (gen_add) begin
            xor_in = xor_ff ^ gen_char;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         xor_ff       <= 8'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         xor_ff       <= xor_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

### hw/rtl/pcdin_checker.sv
// pcdin_checker: port-level assertions for the $PCDIN sentence encoder and
// the bind that attaches them to the top level. Depends on pcdin_pkg.

module pcdin_checker import pcdin_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp
);

   // no word survives reset on the output
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a word that emits characters keeps the input closed next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall &&
       (req.first_item || req.last_item || req.has_byte)) |=> req_stall)
      else $error("input reopened before the word was sequenced");

   // a word with nothing to emit leaves the block ready
   a_empty_word_ready: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall &&
       !req.first_item && !req.last_item && !req.has_byte) |=> !req_stall)
      else $error("empty word made the block busy");

   // a stalled output word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
      else $error("stalled output word changed");

endmodule

bind pcdin_sentence_encoder_core pcdin_checker u_pcdin_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

### test/tb_pcdin_sentence_encoder_core.sv
// tb_pcdin_sentence_encoder_core: self-checking bench for the $PCDIN sentence encoder.
// It predicts or is given each output character and run_end flag, checked in order.
// Depends on pcdin_pkg and pcdin_sentence_encoder_core.

module tb_pcdin_sentence_encoder_core;
   import pcdin_pkg::*;

   localparam int RANDOM_WORDS   = 480;
   localparam int IDLE_PCT       = 27;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 1500;
   localparam int DRAIN_CYCLES   = 40;
   localparam logic [127:0] HEX_DIGITS   = "0123456789ABCDEF";
   localparam logic [47:0]  SENTENCE_TAG = "PCDIN,";

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req       = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   pcdin_sentence_encoder_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   // predicted sentence state and characters
   logic [7:0] sentence_xor = '0;
   rsp_type    word_chars[$];
   rsp_type    pending_chars[$];

   int error_count    = 0;
   int quiet_cycles   = 0;
   int send_idle_pct  = IDLE_PCT;
   int recv_stall_pct = IDLE_PCT;
   bit hold_request   = 1'b0;

   // directed stimulus table
   req_type plan_words[$];
   bit      plan_typed[$];
   string   plan_text[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void put_sentence_char(logic [7:0] c, bit to_sum);
      rsp_type r;
      r.out_char = c;
      r.run_end  = 1'b0;
      word_chars.push_back(r);
      if (to_sum) begin
         sentence_xor = sentence_xor ^ c;
      end
   endfunction

   function automatic void put_hex_digits(logic [31:0] value, int digits, bit to_sum);
      logic [3:0] nib;
      for (int i = digits - 1; i >= 0; i--) begin
         nib = value[i*4 +: 4];
         put_sentence_char(HEX_DIGITS[(15 - nib)*8 +: 8], to_sum);
      end
   endfunction

   // characters caused by one accepted word, left in word_chars
   function automatic void encode_word(req_type w);
      logic [7:0] sum;
      word_chars.delete();
      if (w.first_item) begin
         sentence_xor = '0;
         put_sentence_char(CH_DOLLAR, 1'b0);
         for (int i = 0; i < 6; i++) begin
            put_sentence_char(SENTENCE_TAG[(5 - i)*8 +: 8], 1'b1);
         end
         put_hex_digits(32'(w.pgn_value), 6, 1'b1);
         put_sentence_char(CH_COMMA, 1'b1);
         put_hex_digits(w.time_stamp, 8, 1'b1);
         put_sentence_char(CH_COMMA, 1'b1);
         put_hex_digits(32'(w.source_addr), 2, 1'b1);
         put_sentence_char(CH_COMMA, 1'b1);
      end
      if (w.has_byte) begin
         put_hex_digits(32'(w.data_byte), 2, 1'b1);
      end
      if (w.last_item) begin
         sum = sentence_xor;
         put_sentence_char(CH_STAR, 1'b0);
         put_hex_digits(32'(sum), 2, 1'b0);
         put_sentence_char(CH_CR, 1'b0);
         put_sentence_char(CH_LF, 1'b0);
         sentence_xor = '0;
      end
      if (word_chars.size() > 0) begin
         word_chars[word_chars.size() - 1].run_end = 1'b1;
      end
   endfunction

   // hand-written expectation replaces the predicted characters
   function automatic void load_typed_text(string text);
      rsp_type r;
      word_chars.delete();
      for (int i = 0; i < text.len(); i++) begin
         r.out_char = text[i];
         r.run_end  = (i == text.len() - 1);
         word_chars.push_back(r);
      end
   endfunction

   function automatic req_type make_word(bit f, bit l, bit h);
      req_type w;
      int      pick;
      w.first_item  = f;
      w.last_item   = l;
      w.has_byte    = h;
      w.data_byte   = 8'($urandom_range(255));
      w.pgn_value   = 24'($urandom_range(24'hFFFFFF));
      w.time_stamp  = $urandom;
      w.source_addr = 8'($urandom_range(255));
      pick = $urandom_range(15);
      if (pick == 0) begin
         w.data_byte   = '0;
         w.pgn_value   = '0;
         w.time_stamp  = '0;
         w.source_addr = '0;
      end else if (pick == 1) begin
         w.data_byte   = '1;
         w.pgn_value   = '1;
         w.time_stamp  = '1;
         w.source_addr = '1;
      end
      return w;
   endfunction

   function automatic void add_row(bit f, bit l, bit h, logic [7:0] d, logic [23:0] pgn,
                                   logic [31:0] ts, logic [7:0] src, bit typed, string text);
      req_type w;
      w.first_item  = f;
      w.last_item   = l;
      w.has_byte    = h;
      w.data_byte   = d;
      w.pgn_value   = pgn;
      w.time_stamp  = ts;
      w.source_addr = src;
      plan_words.push_back(w);
      plan_typed.push_back(typed);
      plan_text.push_back(text);
   endfunction

   task automatic send_word(req_type w, bit typed, string text);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= w;
      do @(posedge clock); while (req_stall);
      encode_word(w);
      if (typed) begin
         load_typed_text(text);
      end
      foreach (word_chars[i]) begin
         pending_chars.push_back(word_chars[i]);
      end
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected word: out_char=%h run_end=%b", rsp.out_char, rsp.run_end);
            error_count++;
         end else begin
            want = pending_chars.pop_front();
            if (rsp.out_char !== want.out_char) begin
               $error("out_char: expected %h, got %h", want.out_char, rsp.out_char);
               error_count++;
            end
            if (rsp.run_end !== want.run_end) begin
               $error("run_end: expected %b, got %b", want.run_end, rsp.run_end);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("pcdin_sentence_encoder_core verification failed");
         $finish;
      end
   end

   initial begin
      req_type w;
      int      body_len;
      int      random_sent;
      bit      hold_done;

      random_sent = 0;
      hold_done   = 1'b0;

      //      f  l  h  data   pgn        time_stamp    src    typed  text
      add_row(0, 0, 0, 8'h00, 24'h000000, 32'h00000000, 8'h00, 1, "");
      add_row(0, 0, 1, 8'h00, 24'h000000, 32'h00000000, 8'h00, 1, "00");
      add_row(0, 0, 1, 8'hFF, 24'hFFFFFF, 32'hFFFFFFFF, 8'hFF, 1, "FF");
      add_row(0, 1, 0, 8'h00, 24'h000000, 32'h00000000, 8'h00, 1, "*00\015\012");
      // trailer cleared the checksum
      add_row(0, 1, 0, 8'hFF, 24'hFFFFFF, 32'hFFFFFFFF, 8'hFF, 1, "*00\015\012");
      add_row(1, 0, 0, 8'h00, 24'h000000, 32'h00000000, 8'h00, 1,
              "$PCDIN,000000,00000000,00,");
      add_row(0, 0, 1, 8'hA5, 24'h000000, 32'h00000000, 8'h00, 0, "");
      add_row(0, 1, 1, 8'h5A, 24'h000000, 32'h00000000, 8'h00, 0, "");
      add_row(1, 1, 1, 8'hFF, 24'hFFFFFF, 32'hFFFFFFFF, 8'hFF, 0, "");
      add_row(1, 1, 0, 8'h00, 24'h123456, 32'h89ABCDEF, 8'h7E, 0, "");
      add_row(1, 0, 1, 8'h0F, 24'hABCDEF, 32'h01234567, 8'h81, 0, "");
      add_row(0, 0, 1, 8'h9A, 24'h000000, 32'h00000000, 8'h00, 0, "");
      // new header while a sentence is still open
      add_row(1, 0, 1, 8'hF0, 24'h5A5A5A, 32'hA5A5A5A5, 8'h3C, 0, "");
      add_row(0, 1, 1, 8'h19, 24'h000000, 32'h00000000, 8'h00, 0, "");
      add_row(0, 0, 0, 8'hFF, 24'hFFFFFF, 32'hFFFFFFFF, 8'hFF, 1, "");
      // payload with no header, fresh checksum
      add_row(0, 0, 1, 8'h3C, 24'h000000, 32'h00000000, 8'h00, 0, "");
      add_row(0, 1, 0, 8'h00, 24'h000000, 32'h00000000, 8'h00, 0, "");

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan_words[i]) begin
         send_word(plan_words[i], plan_typed[i], plan_text[i]);
      end

      while (random_sent < RANDOM_WORDS) begin
         if (random_sent >= 100 && !hold_done) begin
            hold_request = 1'b1;
            hold_done    = 1'b1;
         end
         // long stretch with no idling on either side
         if (random_sent >= 220 && random_sent < 320) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end else begin
            send_idle_pct  = IDLE_PCT;
            recv_stall_pct = IDLE_PCT;
         end
         if ($urandom_range(99) < 80) begin
            body_len = $urandom_range(8);
            if (body_len == 0 && $urandom_range(1) == 1) begin
               send_word(make_word(1'b1, 1'b1, 1'($urandom_range(1))), 1'b0, "");
               random_sent++;
            end else begin
               send_word(make_word(1'b1, 1'b0, 1'($urandom_range(1))), 1'b0, "");
               random_sent++;
               repeat (body_len) begin
                  send_word(make_word(1'b0, 1'b0, 1'b1), 1'b0, "");
                  random_sent++;
               end
               send_word(make_word(1'b0, 1'b1, 1'($urandom_range(1))), 1'b0, "");
               random_sent++;
            end
         end else begin
            w = make_word(1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            send_word(w, 1'b0, "");
            if (w.first_item || w.last_item || w.has_byte) begin
               random_sent++;
            end
         end
      end
      req_valid <= 1'b0;

      while (pending_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("pcdin_sentence_encoder_core verification clean");
      end else begin
         $display("pcdin_sentence_encoder_core verification failed");
      end
      $finish;
   end

endmodule
